[design/lts_pkg.sv]
// lts_pkg: shared types, token kind codes, character codes and keyword table
// for the lua token scanner. No dependencies.
package lts_pkg;

    localparam int SRC_BYTES_DEF = 1048576;
    localparam int MAX_LVL_DEF   = 15;
    localparam int KEYWORD_CHARS = 8;
    localparam int MAX_RESULTS   = 12;
    localparam int KW_COUNT      = 21;
    localparam int LVL_W         = 5;   // open level, up to 31
    localparam int CLS_W         = 6;   // close level, up to 63
    localparam int Q_DEPTH       = 4;

    // token kinds
    localparam logic [5:0] K_PLUS     = 6'd21;
    localparam logic [5:0] K_MINUS    = 6'd22;
    localparam logic [5:0] K_STAR     = 6'd23;
    localparam logic [5:0] K_SLASH    = 6'd24;
    localparam logic [5:0] K_PERCENT  = 6'd25;
    localparam logic [5:0] K_CARET    = 6'd26;
    localparam logic [5:0] K_HASH     = 6'd27;
    localparam logic [5:0] K_EQ       = 6'd28;
    localparam logic [5:0] K_LE       = 6'd29;
    localparam logic [5:0] K_GE       = 6'd30;
    localparam logic [5:0] K_LT       = 6'd31;
    localparam logic [5:0] K_GT       = 6'd32;
    localparam logic [5:0] K_NE       = 6'd33;
    localparam logic [5:0] K_ASSIGN   = 6'd34;
    localparam logic [5:0] K_LPAREN   = 6'd35;
    localparam logic [5:0] K_RPAREN   = 6'd36;
    localparam logic [5:0] K_LBRACE   = 6'd37;
    localparam logic [5:0] K_RBRACE   = 6'd38;
    localparam logic [5:0] K_LBRACKET = 6'd39;
    localparam logic [5:0] K_RBRACKET = 6'd40;
    localparam logic [5:0] K_SEMI     = 6'd41;
    localparam logic [5:0] K_COLON    = 6'd42;
    localparam logic [5:0] K_COMMA    = 6'd43;
    localparam logic [5:0] K_DOT      = 6'd44;
    localparam logic [5:0] K_DOT2     = 6'd45;
    localparam logic [5:0] K_DOT3     = 6'd46;
    localparam logic [5:0] K_NUMBER   = 6'd47;
    localparam logic [5:0] K_STRING   = 6'd48;
    localparam logic [5:0] K_NAME     = 6'd49;
    localparam logic [5:0] K_EOF      = 6'd50;
    localparam logic [5:0] K_ERROR    = 6'd51;
    localparam logic [5:0] K_UNTERM   = 6'd52;
    localparam logic [5:0] K_BADNUM   = 6'd53;

    // characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [8:0] END_MARK = 9'h100;

    // keywords, right aligned, first character highest
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        "and", "break", "do", "else", "elseif", "end", "false", "for",
        "function", "if", "in", "local", "nil", "not", "or", "repeat",
        "return", "then", "true", "until", "while"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3, 4'd5, 4'd3, 4'd8, 4'd2, 4'd2,
        4'd5, 4'd3, 4'd3, 4'd2, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] start;
        logic [19:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } t_token;

    typedef struct packed {
        logic   v0;
        t_token d0;
        logic   v1;
        t_token d1;
    } t_push;

    function automatic logic [5:0] kw_kind(input logic [63:0] wb, input logic [3:0] wl);
        logic [5:0] k;
        k = K_NAME;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (wl == KW_LEN[i] && wb == KW_TEXT[i]) k = 6'(i);
        end
        return k;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] x);
        return (x == 16'hFFFF) ? x : x + 16'd1;
    endfunction

endpackage

[design/lts_if.sv]
// lts_if: stream interfaces for source bytes in and token records out.
// No dependencies.
interface lts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       byte_valid;
    logic       end_of_source;
    modport source(output valid, char_byte, byte_valid, end_of_source, input ready);
    modport sink(input valid, char_byte, byte_valid, end_of_source, output ready);
endinterface

interface lts_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [19:0] start_offset;
    logic [19:0] lexeme_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;
    modport source(output valid, token_kind, start_offset, lexeme_length, line_number,
                   column_number, last_of_run, input ready);
    modport sink(input valid, token_kind, start_offset, lexeme_length, line_number,
                 column_number, last_of_run, output ready);
endinterface

[design/lts_front.sv]
// lts_front: accepts source bytes and runs the scanner state machine, one
// character step per cycle while the queue has room for two records, pushing
// token records into the queue. Depends on lts_pkg and lts_in_if.
module lts_front import lts_pkg::*; #(
    parameter int SOURCE_BYTES      = SRC_BYTES_DEF,
    parameter int MAX_BRACKET_LEVEL = MAX_LVL_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lts_in_if.sink     i_in,
    input  logic       i_space2,
    output t_push      o_push
);
    localparam int OFF_W = $clog2(SOURCE_BYTES);
    localparam logic [OFF_W:0]     SRC_N = (OFF_W + 1)'(SOURCE_BYTES);
    localparam logic [LVL_W-1:0]   MAX_L = LVL_W'(MAX_BRACKET_LEVEL);
    localparam logic [3:0]         KW_N  = 4'(KEYWORD_CHARS);
    localparam logic [3:0]         CAP   = 4'(MAX_RESULTS);

    typedef enum logic [4:0] {
        M_IDLE, M_NAME, M_ZERO, M_INT, M_INT_DOT, M_FRAC, M_FRAC_DOT, M_BADNUM,
        M_EXP, M_EXP_SIGN, M_EXP_DIG, M_HEX0, M_HEX, M_DOT1, M_DOT2, M_OP2,
        M_DASH, M_CMT_START, M_CMT_BR, M_CMT_SHORT, M_CMT_LONG, M_CMT_CLOSE,
        M_BR_OPEN, M_LSTR, M_LSTR_CLOSE, M_STR
    } t_mode;

    typedef enum logic {PH_IDLE, PH_RUN} t_phase;

    function automatic logic [OFF_W-1:0] f_next(input logic [OFF_W-1:0] x);
        logic [OFF_W:0] s;
        s = {1'b0, x} + (OFF_W + 1)'(1);
        return (s >= SRC_N) ? '0 : s[OFF_W-1:0];
    endfunction

    function automatic logic [19:0] f_span(input logic [OFF_W-1:0] a,
                                           input logic [OFF_W-1:0] b);
        logic [OFF_W:0] d;
        if (b >= a) d = {1'b0, b} - {1'b0, a};
        else d = {1'b0, b} + SRC_N - {1'b0, a};
        return 20'(d);
    endfunction

    t_phase            r_phase, n_phase;
    t_mode             r_mode, n_mode;
    logic [OFF_W-1:0]  r_ts, n_ts, r_off, n_off, r_dot_off, n_dot_off, r_rp_off, n_rp_off;
    logic [15:0]       r_line, n_line, r_col, n_col, r_sl, n_sl, r_sc, n_sc;
    logic [15:0]       r_dot_col, n_dot_col, r_rp_col, n_rp_col;
    logic [63:0]       r_wb, n_wb;
    logic [3:0]        r_wl, n_wl, r_cnt, n_cnt;
    logic [LVL_W-1:0]  r_bl, n_bl, r_rp_cnt, n_rp_cnt;
    logic [CLS_W-1:0]  r_cl, n_cl;
    logic              r_quote, n_quote, r_esc, n_esc, r_eos, n_eos;
    logic [19:0]       r_crlf, n_crlf;
    logic [8:0]        r_ch, n_ch;
    logic [7:0]        r_rp_ch, n_rp_ch;
    logic              r_hold_v, n_hold_v;
    t_token            r_hold, n_hold;

    logic              is_idle, empty_item, step_do, rp_act, cur_eos;
    logic [8:0]        cur_c, c;
    logic [7:0]        ch;
    logic              isb, is_dig, is_alp, is_hex, esc_hit;
    logic [OFF_W-1:0]  p_off, p_next;
    logic [15:0]       p_col;
    logic              h_emit, h_rescan, h_unterm, h_rp_start;
    logic [5:0]        h_kind;
    logic [OFF_W-1:0]  h_start, h_end, h_rp_off;
    logic [15:0]       h_line, h_col, h_rp_col;
    logic [LVL_W-1:0]  h_rp_n;
    logic [7:0]        h_rp_ch, quote_ch;
    logic [19:0]       h_len;
    logic              done_char, fin, fin_end, tok_ok;
    logic [3:0]        cnt_base;
    t_token            tok;

    assign is_idle    = (r_phase == PH_IDLE);
    assign i_in.ready = is_idle && i_space2;
    assign empty_item = is_idle && !i_in.byte_valid && !i_in.end_of_source;
    assign step_do    = (is_idle ? i_in.valid : 1'b1) && i_space2 && !empty_item;
    assign cur_c      = is_idle ? (i_in.byte_valid ? {1'b0, i_in.char_byte} : END_MARK) : r_ch;
    assign cur_eos    = is_idle ? i_in.end_of_source : r_eos;
    assign rp_act     = (r_rp_cnt != '0);
    assign c          = rp_act ? {1'b0, r_rp_ch} : cur_c;
    assign p_off      = rp_act ? r_rp_off : r_off;
    assign p_col      = rp_act ? r_rp_col : r_col;
    assign p_next     = f_next(p_off);
    assign ch         = c[7:0];
    assign isb        = !c[8];
    assign is_dig     = isb && (ch inside {["0":"9"]});
    assign is_alp     = isb && (ch inside {["a":"z"], ["A":"Z"]});
    assign is_hex     = is_dig || (isb && (ch inside {["a":"f"], ["A":"F"]}));
    assign quote_ch   = r_quote ? CH_SQ : CH_DQ;
    assign esc_hit    = r_esc && (ch inside {"n", "t", "r", CH_BSL, CH_SQ, CH_DQ});
    assign cnt_base   = is_idle ? 4'd0 : r_cnt;

    // one scanner step on the selected character
    always_comb begin
        n_mode = r_mode; n_ts = r_ts; n_sl = r_sl; n_sc = r_sc; n_wb = r_wb; n_wl = r_wl;
        n_bl = r_bl; n_cl = r_cl; n_quote = r_quote; n_esc = r_esc; n_crlf = r_crlf;
        n_dot_off = r_dot_off; n_dot_col = r_dot_col;
        h_emit = 1'b0; h_kind = K_ERROR; h_start = r_ts; h_end = p_off;
        h_line = r_sl; h_col = r_sc; h_rescan = 1'b0; h_unterm = 1'b0;
        h_rp_start = 1'b0; h_rp_n = '0; h_rp_ch = CH_EQ; h_rp_off = r_ts; h_rp_col = r_sc;
        case (r_mode)
            M_NAME: begin
                if (is_alp || is_dig || (isb && ch == CH_USCORE)) begin
                    if (r_wl < KW_N) n_wb = {r_wb[55:0], ch};
                    if (r_wl <= KW_N) n_wl = r_wl + 4'd1;
                end else begin
                    h_emit = 1'b1; h_kind = kw_kind(r_wb, r_wl);
                    n_mode = M_IDLE; h_rescan = 1'b1;
                end
            end
            M_ZERO: begin
                if (isb && (ch == "x" || ch == "X")) n_mode = M_HEX0;
                else begin n_mode = M_INT; h_rescan = 1'b1; end
            end
            M_INT, M_FRAC: begin
                if (is_dig) begin
                end else if (isb && ch == CH_DOT) begin
                    n_dot_off = p_off; n_dot_col = p_col;
                    n_mode = (r_mode == M_INT) ? M_INT_DOT : M_FRAC_DOT;
                end else if (isb && (ch == "e" || ch == "E")) begin
                    n_mode = M_EXP;
                end else begin
                    h_emit = 1'b1; h_kind = K_NUMBER; n_mode = M_IDLE; h_rescan = 1'b1;
                end
            end
            M_INT_DOT, M_FRAC_DOT: begin
                if (is_dig) n_mode = (r_mode == M_INT_DOT) ? M_FRAC : M_BADNUM;
                else begin
                    // number ends before the dot, dot is scanned again
                    h_emit = 1'b1; h_kind = K_NUMBER; h_end = r_dot_off;
                    n_mode = M_IDLE; h_rescan = 1'b1;
                    h_rp_start = 1'b1; h_rp_n = LVL_W'(1); h_rp_ch = CH_DOT;
                    h_rp_off = r_dot_off; h_rp_col = r_dot_col;
                end
            end
            M_BADNUM, M_EXP_DIG, M_HEX: begin
                if ((r_mode == M_HEX) ? is_hex : is_dig) begin
                end else begin
                    h_emit = 1'b1; h_kind = (r_mode == M_BADNUM) ? K_BADNUM : K_NUMBER;
                    n_mode = M_IDLE; h_rescan = 1'b1;
                end
            end
            M_EXP, M_EXP_SIGN: begin
                if (r_mode == M_EXP && isb && (ch == CH_PLUS || ch == CH_DASH))
                    n_mode = M_EXP_SIGN;
                else if (is_dig) n_mode = M_EXP_DIG;
                else begin
                    h_emit = 1'b1; h_kind = K_ERROR; n_mode = M_IDLE; h_rescan = 1'b1;
                end
            end
            M_HEX0: begin
                if (is_hex) n_mode = M_HEX;
                else begin
                    h_emit = 1'b1; h_kind = K_ERROR; n_mode = M_IDLE; h_rescan = 1'b1;
                end
            end
            M_DOT1: begin
                if (isb && ch == CH_DOT) n_mode = M_DOT2;
                else begin
                    h_emit = 1'b1; h_kind = K_DOT; n_mode = M_IDLE; h_rescan = 1'b1;
                end
            end
            M_DOT2: begin
                h_emit = 1'b1; n_mode = M_IDLE;
                if (isb && ch == CH_DOT) begin h_kind = K_DOT3; h_end = p_next; end
                else begin h_kind = K_DOT2; h_rescan = 1'b1; end
            end
            M_OP2: begin
                h_emit = 1'b1; n_mode = M_IDLE;
                if (isb && ch == CH_EQ) begin
                    h_end = p_next;
                    h_kind = (r_wb[7:0] == CH_EQ) ? K_EQ : (r_wb[7:0] == CH_LT) ? K_LE :
                             (r_wb[7:0] == CH_GT) ? K_GE : K_NE;
                end else begin
                    h_rescan = 1'b1;
                    h_kind = (r_wb[7:0] == CH_EQ) ? K_ASSIGN : (r_wb[7:0] == CH_LT) ? K_LT :
                             (r_wb[7:0] == CH_GT) ? K_GT : K_ERROR;
                end
            end
            M_DASH: begin
                if (isb && ch == CH_DASH) n_mode = M_CMT_START;
                else begin
                    h_emit = 1'b1; h_kind = K_MINUS; n_mode = M_IDLE; h_rescan = 1'b1;
                end
            end
            M_CMT_START: begin
                if (isb && ch == CH_LBR) begin n_mode = M_CMT_BR; n_bl = '0; end
                else begin n_mode = M_CMT_SHORT; h_rescan = 1'b1; end
            end
            M_CMT_BR, M_BR_OPEN: begin
                if (isb && ch == CH_EQ && r_bl < MAX_L) n_bl = r_bl + LVL_W'(1);
                else if (isb && ch == CH_LBR) n_mode = (r_mode == M_CMT_BR) ? M_CMT_LONG : M_LSTR;
                else if (r_mode == M_CMT_BR) begin
                    n_mode = M_CMT_SHORT; h_rescan = 1'b1;
                end else begin
                    // failed long open: left bracket, then the equals signs again
                    h_emit = 1'b1; h_kind = K_LBRACKET; h_end = f_next(r_ts);
                    n_mode = M_IDLE; h_rescan = 1'b1;
                    h_rp_start = 1'b1; h_rp_n = r_bl; h_rp_ch = CH_EQ;
                    h_rp_off = f_next(r_ts); h_rp_col = sat_inc16(r_sc);
                end
            end
            M_CMT_SHORT: begin
                if (!isb || ch == CH_LF) begin n_mode = M_IDLE; h_rescan = 1'b1; end
            end
            M_CMT_LONG, M_LSTR: begin
                if (!isb) begin
                    n_mode = M_IDLE;
                    if (r_mode == M_LSTR) begin
                        h_emit = 1'b1; h_kind = K_ERROR; h_rescan = 1'b1;
                    end
                end else if (ch == CH_RBR) begin
                    n_mode = (r_mode == M_LSTR) ? M_LSTR_CLOSE : M_CMT_CLOSE;
                    n_cl = '0;
                end
            end
            M_CMT_CLOSE, M_LSTR_CLOSE: begin
                if (!isb) begin
                    n_mode = M_IDLE;
                    if (r_mode == M_LSTR_CLOSE) begin
                        h_emit = 1'b1; h_kind = K_ERROR; h_rescan = 1'b1;
                    end
                end else if (ch == CH_EQ) begin
                    if (r_cl <= CLS_W'(MAX_L)) n_cl = r_cl + CLS_W'(1);
                end else if (ch == CH_RBR) begin
                    if (r_cl == CLS_W'(r_bl)) begin
                        n_mode = M_IDLE;
                        if (r_mode == M_LSTR_CLOSE) begin
                            h_emit = 1'b1; h_kind = K_STRING; h_end = p_next;
                        end
                    end else n_cl = '0;
                end else begin
                    n_mode = (r_mode == M_LSTR_CLOSE) ? M_LSTR : M_CMT_LONG;
                    h_rescan = 1'b1;
                end
            end
            M_STR: begin
                if (!isb) begin
                    h_emit = 1'b1; h_kind = K_UNTERM; h_unterm = 1'b1;
                    n_mode = M_IDLE; h_rescan = 1'b1;
                end else if (esc_hit) begin
                    n_esc = 1'b0; n_crlf = '0;
                end else begin
                    n_esc = 1'b0;
                    if (ch == quote_ch) begin
                        h_emit = 1'b1; h_kind = K_STRING; h_end = p_next; n_mode = M_IDLE;
                    end else if (ch == CH_BSL) begin
                        n_esc = 1'b1; n_crlf = '0;
                    end else if (ch == CH_LF || ch == CH_CR) begin
                        if (r_crlf != 20'hFFFFF) n_crlf = r_crlf + 20'd1;
                    end else n_crlf = '0;
                end
            end
            default: begin
                // between tokens
                n_mode = M_IDLE;
                if (isb && !(ch inside {CH_SP, CH_TAB, CH_CR, CH_LF})) begin
                    n_ts = p_off; n_sl = r_line; n_sc = p_col;
                    h_start = p_off; h_end = p_next; h_line = r_line; h_col = p_col;
                    if (is_alp || ch == CH_USCORE) begin
                        n_mode = M_NAME; n_wb = {56'd0, ch}; n_wl = 4'd1;
                    end else if (is_dig) begin
                        n_mode = (ch == CH_ZERO) ? M_ZERO : M_INT;
                    end else begin
                        case (ch)
                            "(": begin h_emit = 1'b1; h_kind = K_LPAREN; end
                            ")": begin h_emit = 1'b1; h_kind = K_RPAREN; end
                            "{": begin h_emit = 1'b1; h_kind = K_LBRACE; end
                            "}": begin h_emit = 1'b1; h_kind = K_RBRACE; end
                            CH_RBR: begin h_emit = 1'b1; h_kind = K_RBRACKET; end
                            ";": begin h_emit = 1'b1; h_kind = K_SEMI; end
                            ":": begin h_emit = 1'b1; h_kind = K_COLON; end
                            ",": begin h_emit = 1'b1; h_kind = K_COMMA; end
                            CH_PLUS: begin h_emit = 1'b1; h_kind = K_PLUS; end
                            "*": begin h_emit = 1'b1; h_kind = K_STAR; end
                            "/": begin h_emit = 1'b1; h_kind = K_SLASH; end
                            "%": begin h_emit = 1'b1; h_kind = K_PERCENT; end
                            "^": begin h_emit = 1'b1; h_kind = K_CARET; end
                            "#": begin h_emit = 1'b1; h_kind = K_HASH; end
                            CH_LBR: begin n_mode = M_BR_OPEN; n_bl = '0; end
                            CH_EQ, CH_LT, CH_GT, CH_TILDE: begin
                                n_mode = M_OP2; n_wb = {56'd0, ch};
                            end
                            CH_DOT: n_mode = M_DOT1;
                            CH_DASH: n_mode = M_DASH;
                            CH_DQ, CH_SQ: begin
                                n_mode = M_STR; n_quote = (ch == CH_SQ);
                                n_esc = 1'b0; n_crlf = '0;
                            end
                            default: begin h_emit = 1'b1; h_kind = K_ERROR; end
                        endcase
                    end
                end
            end
        endcase
        h_len = f_span(h_start, h_end);
        if (h_unterm && (r_crlf < h_len)) h_len = h_len - r_crlf;
    end

    // sequencing of replay, rescan, position advance and token release
    always_comb begin
        n_phase = r_phase; n_off = r_off; n_line = r_line; n_col = r_col;
        n_ch = r_ch; n_eos = r_eos; n_rp_cnt = r_rp_cnt; n_rp_ch = r_rp_ch;
        n_rp_off = r_rp_off; n_rp_col = r_rp_col; n_cnt = r_cnt;
        n_hold_v = r_hold_v; n_hold = r_hold;
        done_char = 1'b0; fin = 1'b0; fin_end = 1'b0; tok_ok = 1'b0;
        tok = '0;
        o_push = '0;
        if (step_do) begin
            if (h_rp_start && h_rp_n != '0) begin
                n_rp_cnt = h_rp_n; n_rp_ch = h_rp_ch; n_rp_off = h_rp_off; n_rp_col = h_rp_col;
            end else if (rp_act) begin
                if (!h_rescan) begin
                    n_rp_cnt = r_rp_cnt - LVL_W'(1);
                    n_rp_off = f_next(r_rp_off);
                    n_rp_col = sat_inc16(r_rp_col);
                end
            end else if (!h_rescan) begin
                done_char = 1'b1;
            end
            n_ch = cur_c; n_eos = cur_eos; n_phase = PH_RUN;
            if (done_char) begin
                if (!cur_c[8]) begin
                    n_off = f_next(r_off);
                    if (cur_c[7:0] == CH_LF) begin
                        n_line = sat_inc16(r_line); n_col = 16'd1;
                    end else n_col = sat_inc16(r_col);
                    if (cur_eos) n_ch = END_MARK;
                    else fin = 1'b1;
                end else begin
                    fin = 1'b1; fin_end = 1'b1;
                    n_off = '0; n_line = 16'd1; n_col = 16'd1;
                end
            end
            if (fin) n_phase = PH_IDLE;

            if (fin_end) begin
                tok.kind = K_EOF; tok.start = 20'(r_off); tok.len = '0;
                tok.line = r_line; tok.col = r_col;
            end else begin
                tok.kind = h_kind; tok.start = 20'(h_start); tok.len = h_len;
                tok.line = h_line; tok.col = h_col;
            end
            tok_ok = (fin_end || h_emit) && (cnt_base < CAP);
            n_cnt = cnt_base + {3'd0, tok_ok};

            // a token waits in the hold slot until it is known whether it is last
            if (tok_ok && !fin) begin
                o_push.v0 = r_hold_v; o_push.d0 = r_hold;
                n_hold_v = 1'b1; n_hold = tok;
            end else if (tok_ok) begin
                tok.last = 1'b1;
                if (r_hold_v) begin
                    o_push.v0 = 1'b1; o_push.d0 = r_hold; o_push.v1 = 1'b1; o_push.d1 = tok;
                end else begin
                    o_push.v0 = 1'b1; o_push.d0 = tok;
                end
                n_hold_v = 1'b0;
            end else if (fin && r_hold_v) begin
                o_push.v0 = 1'b1; o_push.d0 = r_hold; o_push.d0.last = 1'b1;
                n_hold_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_mode <= M_IDLE; r_ts <= '0; r_off <= '0;
            r_line <= 16'd1; r_col <= 16'd1; r_sl <= 16'd1; r_sc <= 16'd1;
            r_wb <= '0; r_wl <= '0; r_bl <= '0; r_cl <= '0; r_quote <= 1'b0;
            r_esc <= 1'b0; r_crlf <= '0; r_dot_off <= '0; r_dot_col <= 16'd1;
            r_ch <= '0; r_eos <= 1'b0; r_rp_cnt <= '0; r_rp_ch <= '0;
            r_rp_off <= '0; r_rp_col <= 16'd1; r_cnt <= '0; r_hold_v <= 1'b0;
            r_hold <= '0;
        end else begin
            r_phase <= n_phase; r_off <= n_off; r_line <= n_line; r_col <= n_col;
            r_ch <= n_ch; r_eos <= n_eos; r_rp_cnt <= n_rp_cnt; r_rp_ch <= n_rp_ch;
            r_rp_off <= n_rp_off; r_rp_col <= n_rp_col; r_cnt <= n_cnt;
            r_hold_v <= n_hold_v; r_hold <= n_hold;
            if (step_do && fin_end) begin
                r_mode <= M_IDLE; r_ts <= '0; r_sl <= 16'd1; r_sc <= 16'd1;
                r_wb <= '0; r_wl <= '0; r_bl <= '0; r_cl <= '0; r_quote <= 1'b0;
                r_esc <= 1'b0; r_crlf <= '0; r_dot_off <= '0; r_dot_col <= 16'd1;
            end else if (step_do) begin
                r_mode <= n_mode; r_ts <= n_ts; r_sl <= n_sl; r_sc <= n_sc;
                r_wb <= n_wb; r_wl <= n_wl; r_bl <= n_bl; r_cl <= n_cl;
                r_quote <= n_quote; r_esc <= n_esc; r_crlf <= n_crlf;
                r_dot_off <= n_dot_off; r_dot_col <= n_dot_col;
            end
        end
    end

endmodule

[design/lts_queue.sv]
// lts_queue: short token queue between scanner and output stage, two
// writes and one read per cycle. Depends on lts_pkg.
module lts_queue import lts_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output t_token o_head,
    output logic   o_nonempty,
    output logic   o_space2
);
    localparam int QP_W = $clog2(Q_DEPTH);
    localparam int QC_W = QP_W + 1;

    t_token            r_mem [Q_DEPTH];
    logic [QP_W-1:0]   r_wr, r_rd;
    logic [QC_W-1:0]   r_count, n_count;

    assign o_head     = r_mem[r_rd];
    assign o_nonempty = (r_count != '0);
    assign o_space2   = (r_count <= QC_W'(Q_DEPTH - 2));
    assign n_count    = r_count + QC_W'(i_push.v0) + QC_W'(i_push.v1) - QC_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wr] <= i_push.d0;
        if (i_push.v1) r_mem[r_wr + QP_W'(1)] <= i_push.d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_count <= '0;
        end else begin
            r_wr <= r_wr + QP_W'(i_push.v0) + QP_W'(i_push.v1);
            r_rd <= r_rd + QP_W'(i_pop);
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> i_push.v0) else $error("second write without first");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> r_count <= QC_W'(Q_DEPTH - 2)) else $error("queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0) else $error("pop from empty queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_push.v0 && !i_pop |=> $stable(r_count)) else $error("count moved while idle");
`endif

endmodule

[design/lts_back.sv]
// lts_back: output register that drains the token queue onto the result
// channel. Depends on lts_pkg and lts_out_if.
module lts_back import lts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_token     i_head,
    input  logic       i_nonempty,
    output logic       o_pop,
    lts_out_if.source  o_out
);
    logic   r_valid;
    t_token r_tok;

    assign o_pop = i_nonempty && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (o_pop) r_valid <= 1'b1;
        else if (o_out.ready) r_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_tok <= i_head;
    end

    assign o_out.valid         = r_valid;
    assign o_out.token_kind    = r_tok.kind;
    assign o_out.start_offset  = r_tok.start;
    assign o_out.lexeme_length = r_tok.len;
    assign o_out.line_number   = r_tok.line;
    assign o_out.column_number = r_tok.col;
    assign o_out.last_of_run   = r_tok.last;

endmodule

[design/lua_token_scanner_top.sv]
// Lua token scanner top level. Source bytes come in on i_in, one item per
// handshake; token records leave on o_out. The front scanner steps one
// character per cycle while the queue has room for two records, and a
// four-entry queue parts it from the output register. Each rescan of a byte
// that closed a token, each replayed byte after a failed long open (one per
// equals sign) or after a number ending at a dot, and the flush and end
// token on end_of_source each take a scanner step of their own.
// A released token passes through the queue and then the output register;
// a token is released once the word that ends it is processed, the last
// one of a word carrying last_of_run.
// When o_out stalls, the queue fills and i_in.ready drops until two queue
// entries are free; no token is lost.
// Reset (i_rst_n low, synchronous) returns to line 1, column 1, offset 0 and
// empties the queue and output register. end_of_source also returns the
// scanner to that state after the end token.
// Depends on lts_pkg, lts_if, lts_front, lts_queue and lts_back.
module lua_token_scanner_top import lts_pkg::*; #(
    parameter int SOURCE_BYTES      = SRC_BYTES_DEF,
    parameter int MAX_BRACKET_LEVEL = MAX_LVL_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lts_in_if.sink    i_in,
    lts_out_if.source o_out
);
    t_push  push;
    t_token head;
    logic   space2, nonempty, pop;

    lts_front #(
        .SOURCE_BYTES      (SOURCE_BYTES),
        .MAX_BRACKET_LEVEL (MAX_BRACKET_LEVEL)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_space2 (space2),
        .o_push   (push)
    );

    lts_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (pop),
        .o_head     (head),
        .o_nonempty (nonempty),
        .o_space2   (space2)
    );

    lts_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_nonempty (nonempty),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

[dv/tb_lua_token_scanner_top.sv]
// Testbench for lua_token_scanner_top: a directed table then random Lua-like
// text, every token record checked against an in-bench scanner model.
// Depends on lts_pkg, lts_if and the scanner RTL.
`timescale 1ns / 1ps

module tb_lua_token_scanner_top;
    import lts_pkg::*;

    localparam int SRC = SRC_BYTES_DEF;
    localparam int MAX_LVL = MAX_LVL_DEF;
    localparam int END_CH = 256;
    localparam int RAND_ITEMS = 360;
    localparam int STALL_LIMIT = 4000;

    typedef enum {
        S_IDLE, S_NAME, S_ZERO, S_INT, S_INT_DOT, S_FRAC, S_FRAC_DOT, S_BADNUM,
        S_EXP, S_EXP_SIGN, S_EXP_DIG, S_HEX0, S_HEX, S_DOT1, S_DOT2, S_OP2,
        S_DASH, S_CMT_START, S_CMT_BR, S_CMT_SHORT, S_CMT_LONG, S_CMT_CLOSE,
        S_BR_OPEN, S_LSTR, S_LSTR_CLOSE, S_STR
    } t_scan_st;

    typedef struct {
        logic [7:0] c;
        bit         bv;
        bit         eos;
        bit         typed;
        t_token     tok;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    lts_in_if  in_bus();
    lts_out_if out_bus();

    lua_token_scanner_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    string kw_names [21] = '{
        "and", "break", "do", "else", "elseif", "end", "false", "for",
        "function", "if", "in", "local", "nil", "not", "or", "repeat",
        "return", "then", "true", "until", "while"
    };

    // scanner model state
    t_scan_st    mode;
    int unsigned tok_start, offs, cur_ln, cur_cl, tok_ln, tok_cl;
    logic [63:0] wbuf;
    int unsigned wlen, blevel, clevel, crlf_run, dot_off, dot_cl;
    bit          q_single, esc_pend;

    t_token tok_run[$];
    t_token tokens_due[$];
    int     n_fail;
    int     n_sent;
    bit     calm;
    int     idle_count;

    function automatic int unsigned sat16(int unsigned x);
        return (x >= 65535) ? 65535 : x;
    endfunction

    function automatic int unsigned nxt(int unsigned x);
        return (x + 1 >= SRC) ? 0 : x + 1;
    endfunction

    function automatic int unsigned span(int unsigned a, int unsigned b);
        return (b + SRC - a) % SRC;
    endfunction

    function automatic bit is_dig(int c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alf(int c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_hex(int c);
        return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic void reset_scan();
        mode = S_IDLE;
        tok_start = 0;
        offs = 0;
        cur_ln = 1;
        cur_cl = 1;
        tok_ln = 1;
        tok_cl = 1;
        wbuf = '0;
        wlen = 0;
        blevel = 0;
        clevel = 0;
        q_single = 0;
        esc_pend = 0;
        crlf_run = 0;
        dot_off = 0;
        dot_cl = 1;
    endfunction

    function automatic void put_tok(int kind, int unsigned st, int unsigned ln_b,
                                    int unsigned ln, int unsigned cl);
        t_token t;
        if (tok_run.size() >= MAX_RESULTS) return;
        t.kind = kind[5:0];
        t.start = st[19:0];
        t.len = ln_b[19:0];
        t.line = ln[15:0];
        t.col = cl[15:0];
        t.last = 1'b0;
        tok_run.push_back(t);
    endfunction

    function automatic void close_tok(int kind, int unsigned endp);
        put_tok(kind, tok_start, span(tok_start, endp), tok_ln, tok_cl);
    endfunction

    // returns 1 when the byte must be scanned again
    function automatic bit finish(int kind, bit incl);
        close_tok(kind, incl ? nxt(offs) : offs);
        mode = S_IDLE;
        return !incl;
    endfunction

    function automatic int word_kind();
        logic [63:0] p;
        int k;
        k = K_NAME;
        if (wlen > KEYWORD_CHARS) return k;
        for (int i = 0; i < 21; i++) begin
            p = '0;
            for (int j = 0; j < kw_names[i].len(); j++)
                p |= 64'(kw_names[i][j]) << (8 * j);
            if (kw_names[i].len() == wlen && p == wbuf) k = i;
        end
        return k;
    endfunction

    function automatic void scan_run(int c);
        while (scan_char(c)) begin
        end
    endfunction

    function automatic void rescan_at(int c, int unsigned off, int unsigned cl);
        int unsigned so, sc;
        so = offs;
        sc = cur_cl;
        offs = off;
        cur_cl = cl;
        scan_run(c);
        offs = so;
        cur_cl = sc;
    endfunction

    // failed long open: left bracket, then each equals sign again as an operator
    function automatic bit bracket_fallback();
        int unsigned off, cl, n;
        off = tok_start;
        cl = tok_cl;
        n = blevel;
        close_tok(K_LBRACKET, nxt(tok_start));
        mode = S_IDLE;
        for (int unsigned i = 0; i < n; i++) begin
            off = nxt(off);
            cl = sat16(cl + 1);
            rescan_at(CH_EQ, off, cl);
        end
        return 1;
    endfunction

    function automatic bit number_at_dot();
        close_tok(K_NUMBER, dot_off);
        mode = S_IDLE;
        rescan_at(CH_DOT, dot_off, dot_cl);
        return 1;
    endfunction

    function automatic bit start_tok(int c);
        if (c == END_CH || c == " " || c == CH_TAB || c == CH_CR || c == CH_LF) return 0;
        tok_start = offs;
        tok_ln = cur_ln;
        tok_cl = cur_cl;
        if (is_alf(c) || c == "_") begin
            mode = S_NAME;
            wbuf = 64'(c);
            wlen = 1;
            return 0;
        end
        if (is_dig(c)) begin
            mode = (c == "0") ? S_ZERO : S_INT;
            return 0;
        end
        case (c)
            "(": return finish(K_LPAREN, 1);
            ")": return finish(K_RPAREN, 1);
            "{": return finish(K_LBRACE, 1);
            "}": return finish(K_RBRACE, 1);
            "]": return finish(K_RBRACKET, 1);
            ";": return finish(K_SEMI, 1);
            ":": return finish(K_COLON, 1);
            ",": return finish(K_COMMA, 1);
            "+": return finish(K_PLUS, 1);
            "*": return finish(K_STAR, 1);
            "/": return finish(K_SLASH, 1);
            "%": return finish(K_PERCENT, 1);
            "^": return finish(K_CARET, 1);
            "#": return finish(K_HASH, 1);
            "[": begin
                mode = S_BR_OPEN;
                blevel = 0;
                return 0;
            end
            "=", "<", ">", "~": begin
                mode = S_OP2;
                wbuf = 64'(c);
                return 0;
            end
            ".": begin
                mode = S_DOT1;
                return 0;
            end
            "-": begin
                mode = S_DASH;
                return 0;
            end
            CH_DQ, CH_SQ: begin
                mode = S_STR;
                q_single = (c == CH_SQ);
                esc_pend = 0;
                crlf_run = 0;
                return 0;
            end
            default: return finish(K_ERROR, 1);
        endcase
    endfunction

    function automatic bit scan_char(int c);
        int first, qc;
        int unsigned ln_b;
        case (mode)
            S_NAME: begin
                if (is_alf(c) || is_dig(c) || c == "_") begin
                    if (wlen < KEYWORD_CHARS) wbuf |= 64'(c) << (8 * wlen);
                    if (wlen <= KEYWORD_CHARS) wlen++;
                    return 0;
                end
                return finish(word_kind(), 0);
            end
            S_ZERO: begin
                if (c == "x" || c == "X") begin
                    mode = S_HEX0;
                    return 0;
                end
                mode = S_INT;
                return 1;
            end
            S_INT, S_FRAC: begin
                if (is_dig(c)) return 0;
                if (c == ".") begin
                    dot_off = offs;
                    dot_cl = cur_cl;
                    mode = (mode == S_INT) ? S_INT_DOT : S_FRAC_DOT;
                    return 0;
                end
                if (c == "e" || c == "E") begin
                    mode = S_EXP;
                    return 0;
                end
                return finish(K_NUMBER, 0);
            end
            S_INT_DOT: begin
                if (is_dig(c)) begin
                    mode = S_FRAC;
                    return 0;
                end
                return number_at_dot();
            end
            S_FRAC_DOT: begin
                if (is_dig(c)) begin
                    mode = S_BADNUM;
                    return 0;
                end
                return number_at_dot();
            end
            S_BADNUM: begin
                if (is_dig(c)) return 0;
                return finish(K_BADNUM, 0);
            end
            S_EXP: begin
                if (c == "+" || c == "-") begin
                    mode = S_EXP_SIGN;
                    return 0;
                end
                if (is_dig(c)) begin
                    mode = S_EXP_DIG;
                    return 0;
                end
                return finish(K_ERROR, 0);
            end
            S_EXP_SIGN: begin
                if (is_dig(c)) begin
                    mode = S_EXP_DIG;
                    return 0;
                end
                return finish(K_ERROR, 0);
            end
            S_EXP_DIG: begin
                if (is_dig(c)) return 0;
                return finish(K_NUMBER, 0);
            end
            S_HEX0: begin
                if (is_hex(c)) begin
                    mode = S_HEX;
                    return 0;
                end
                return finish(K_ERROR, 0);
            end
            S_HEX: begin
                if (is_hex(c)) return 0;
                return finish(K_NUMBER, 0);
            end
            S_DOT1: begin
                if (c == ".") begin
                    mode = S_DOT2;
                    return 0;
                end
                return finish(K_DOT, 0);
            end
            S_DOT2: begin
                if (c == ".") return finish(K_DOT3, 1);
                return finish(K_DOT2, 0);
            end
            S_OP2: begin
                first = int'(wbuf[7:0]);
                if (c == "=")
                    return finish(first == "=" ? K_EQ : first == "<" ? K_LE :
                                  first == ">" ? K_GE : K_NE, 1);
                return finish(first == "=" ? K_ASSIGN : first == "<" ? K_LT :
                              first == ">" ? K_GT : K_ERROR, 0);
            end
            S_DASH: begin
                if (c == "-") begin
                    mode = S_CMT_START;
                    return 0;
                end
                return finish(K_MINUS, 0);
            end
            S_CMT_START: begin
                if (c == "[") begin
                    mode = S_CMT_BR;
                    blevel = 0;
                    return 0;
                end
                mode = S_CMT_SHORT;
                return 1;
            end
            S_CMT_BR: begin
                if (c == "=" && blevel < MAX_LVL) begin
                    blevel++;
                    return 0;
                end
                if (c == "[") begin
                    mode = S_CMT_LONG;
                    return 0;
                end
                mode = S_CMT_SHORT;
                return 1;
            end
            S_CMT_SHORT: begin
                if (c == CH_LF || c == END_CH) begin
                    mode = S_IDLE;
                    return 1;
                end
                return 0;
            end
            S_CMT_LONG, S_LSTR: begin
                if (c == END_CH) begin
                    if (mode == S_LSTR) return finish(K_ERROR, 0);
                    mode = S_IDLE;
                    return 0;
                end
                if (c == "]") begin
                    mode = (mode == S_LSTR) ? S_LSTR_CLOSE : S_CMT_CLOSE;
                    clevel = 0;
                end
                return 0;
            end
            S_CMT_CLOSE, S_LSTR_CLOSE: begin
                if (c == END_CH) begin
                    if (mode == S_LSTR_CLOSE) return finish(K_ERROR, 0);
                    mode = S_IDLE;
                    return 0;
                end
                if (c == "=") begin
                    if (clevel <= MAX_LVL) clevel++;
                    return 0;
                end
                if (c == "]") begin
                    if (clevel == blevel) begin
                        if (mode == S_LSTR_CLOSE) return finish(K_STRING, 1);
                        mode = S_IDLE;
                        return 0;
                    end
                    clevel = 0;
                    return 0;
                end
                mode = (mode == S_LSTR_CLOSE) ? S_LSTR : S_CMT_LONG;
                return 1;
            end
            S_BR_OPEN: begin
                if (c == "=" && blevel < MAX_LVL) begin
                    blevel++;
                    return 0;
                end
                if (c == "[") begin
                    mode = S_LSTR;
                    return 0;
                end
                return bracket_fallback();
            end
            S_STR: begin
                if (c == END_CH) begin
                    // trailing line breaks do not count toward an open string
                    ln_b = span(tok_start, offs);
                    if (crlf_run < ln_b) ln_b -= crlf_run;
                    put_tok(K_UNTERM, tok_start, ln_b, tok_ln, tok_cl);
                    mode = S_IDLE;
                    return 1;
                end
                if (esc_pend) begin
                    esc_pend = 0;
                    if (c == "n" || c == "t" || c == "r" || c == CH_BSL || c == CH_SQ ||
                        c == CH_DQ) begin
                        crlf_run = 0;
                        return 0;
                    end
                end
                qc = q_single ? CH_SQ : CH_DQ;
                if (c == qc) return finish(K_STRING, 1);
                if (c == CH_BSL) begin
                    esc_pend = 1;
                    crlf_run = 0;
                end else if (c == CH_LF || c == CH_CR) begin
                    if (crlf_run < 32'hFFFF_FFFF) crlf_run++;
                end else begin
                    crlf_run = 0;
                end
                return 0;
            end
            default: begin
                mode = S_IDLE;
                return start_tok(c);
            end
        endcase
    endfunction

    // tokens caused by one accepted word
    function automatic void predict_tokens(logic [7:0] c, bit bv, bit eos);
        tok_run.delete();
        if (bv) begin
            scan_run(int'(c));
            offs = nxt(offs);
            if (c == CH_LF) begin
                cur_ln = sat16(cur_ln + 1);
                cur_cl = 1;
            end else begin
                cur_cl = sat16(cur_cl + 1);
            end
        end
        if (eos) begin
            scan_run(END_CH);
            put_tok(K_EOF, offs, 0, cur_ln, cur_cl);
            reset_scan();
        end
        if (tok_run.size() > 0) tok_run[tok_run.size() - 1].last = 1'b1;
    endfunction

    function automatic int draw_wait();
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // word sender: holds valid until accepted, then draws a gap
    task automatic send_word(logic [7:0] c, bit bv, bit eos);
        int gap;
        in_bus.valid <= 1'b1;
        in_bus.char_byte <= c;
        in_bus.byte_valid <= bv;
        in_bus.end_of_source <= eos;
        do @(posedge i_clk); while (!in_bus.ready);
        n_sent++;
        predict_tokens(c, bv, eos);
        foreach (tok_run[i]) tokens_due.push_back(tok_run[i]);
        gap = draw_wait();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b1, 1'b0);
    endtask

    // sink side: stalls per word, ready stays high across back-to-back words when no stall is drawn
    initial begin
        int stall;
        out_bus.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!out_bus.valid);
        end
    end

    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (tokens_due.size() == 0) begin
                $display("%0t: token with none expected: kind %0d start %0d", $realtime,
                         out_bus.token_kind, out_bus.start_offset);
                n_fail++;
            end else begin
                want = tokens_due.pop_front();
                if (out_bus.token_kind !== want.kind) begin
                    $display("%0t: kind exp %0d got %0d", $realtime, want.kind,
                             out_bus.token_kind);
                    n_fail++;
                end
                if (out_bus.start_offset !== want.start) begin
                    $display("%0t: start exp %0d got %0d", $realtime, want.start,
                             out_bus.start_offset);
                    n_fail++;
                end
                if (out_bus.lexeme_length !== want.len) begin
                    $display("%0t: length exp %0d got %0d", $realtime, want.len,
                             out_bus.lexeme_length);
                    n_fail++;
                end
                if (out_bus.line_number !== want.line) begin
                    $display("%0t: line exp %0d got %0d", $realtime, want.line,
                             out_bus.line_number);
                    n_fail++;
                end
                if (out_bus.column_number !== want.col) begin
                    $display("%0t: column exp %0d got %0d", $realtime, want.col,
                             out_bus.column_number);
                    n_fail++;
                end
                if (out_bus.last_of_run !== want.last) begin
                    $display("%0t: last exp %0b got %0b", $realtime, want.last,
                             out_bus.last_of_run);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic random_fragment();
        int lvl;
        string s;
        string ops;
        ops = "(){}];:,+*/%^#";
        case ($urandom_range(0, 11))
            0, 1: s = kw_names[$urandom_range(0, 20)];
            2: begin
                s = "";
                s = {s, string'(byte'($urandom_range(0, 1) ? "_" : "a" + $urandom_range(0, 25)))};
                repeat ($urandom_range(0, 10))
                    s = {s, string'(byte'($urandom_range(0, 2) == 0 ?
                                          "0" + $urandom_range(0, 9) :
                                          "A" + $urandom_range(0, 25)))};
            end
            3: begin
                case ($urandom_range(0, 9))
                    0: s = "0x";
                    1: s = "0xAf9";
                    2: s = "1e";
                    3: s = "2E+";
                    4: s = "1.2.3";
                    5: s = "3..";
                    6: s = "12.5e-3";
                    7: s = "007";
                    8: s = "4.x";
                    default: s = $sformatf("%0d", $urandom_range(0, 99999));
                endcase
            end
            4: begin
                s = ($urandom_range(0, 1)) ? "\"" : "'";
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 7))
                        0: s = {s, "\\n"};
                        1: s = {s, "\\\""};
                        2: s = {s, "\\q"};
                        3: s = {s, "\n"};
                        4: s = {s, "\r"};
                        5: s = {s, "'"};
                        default: s = {s, "z"};
                    endcase
                end
                if ($urandom_range(0, 5) != 0) s = {s, s.substr(0, 0)};
            end
            5: begin
                lvl = $urandom_range(0, 3);
                s = "[";
                repeat (lvl) s = {s, "="};
                if ($urandom_range(0, 4) == 0) begin
                    s = {s, "x"};
                end else begin
                    s = {s, "[a]=]\n]"};
                    repeat ($urandom_range(0, 4)) s = {s, "="};
                    s = {s, "]b]"};
                    repeat (lvl) s = {s, "="};
                    s = {s, "]"};
                end
            end
            6: begin
                case ($urandom_range(0, 3))
                    0: s = "-- note +\n";
                    1: s = "--[[ x ]=] ]]";
                    2: s = "--[==[ y ]] ]==]";
                    default: s = "--[=q\n";
                endcase
            end
            7, 8: begin
                case ($urandom_range(0, 13))
                    0: s = "==";
                    1: s = "<=";
                    2: s = ">=";
                    3: s = "~=";
                    4: s = "...";
                    5: s = "..";
                    6: s = ".";
                    7: s = "<";
                    8: s = ">";
                    9: s = "~";
                    10: s = "-";
                    11: s = "=";
                    default: s = string'(ops[$urandom_range(0, 13)]);
                endcase
            end
            9: s = string'(byte'($urandom_range(0, 255)));
            default: s = ($urandom_range(0, 2) == 0) ? "\n" : " ";
        endcase
        send_text(s);
        if ($urandom_range(0, 2) != 0) send_text(($urandom_range(0, 5) == 0) ? "\t" : " ");
    endtask

    t_dir_row dir_tab [] = '{
        '{8'h28, 1, 0, 1, '{K_LPAREN, 20'd0, 20'd1, 16'd1, 16'd1, 1'b1}},
        '{8'hFF, 1, 0, 1, '{K_ERROR, 20'd1, 20'd1, 16'd1, 16'd2, 1'b1}},
        '{CH_TILDE, 1, 0, 0, '0},
        '{CH_SP, 1, 0, 1, '{K_ERROR, 20'd2, 20'd1, 16'd1, 16'd3, 1'b1}},
        '{CH_LBR, 1, 0, 0, '0},
        '{CH_EQ, 1, 0, 0, '0},
        '{8'h28, 1, 0, 0, '0},
        '{CH_SP, 1, 0, 0, '0},
        '{8'h31, 1, 0, 0, '0},
        '{CH_DOT, 1, 0, 0, '0},
        '{CH_DOT, 1, 0, 0, '0},
        '{8'h35, 1, 0, 0, '0},
        '{CH_SP, 1, 0, 0, '0},
        '{CH_ZERO, 1, 0, 0, '0},
        '{8'h78, 1, 0, 0, '0},
        '{8'h00, 0, 1, 0, '0},
        '{CH_DQ, 1, 0, 0, '0},
        '{8'h61, 1, 0, 0, '0},
        '{CH_LF, 1, 0, 0, '0},
        '{8'h00, 0, 1, 0, '0},
        '{CH_DASH, 1, 0, 0, '0},
        '{CH_DASH, 1, 0, 0, '0},
        '{CH_LBR, 1, 0, 0, '0},
        '{CH_LBR, 1, 1, 0, '0}
    };

    initial begin
        t_token got;
        n_fail = 0;
        n_sent = 0;
        calm = 0;
        reset_scan();
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.char_byte = '0;
        in_bus.byte_valid = 1'b0;
        in_bus.end_of_source = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            send_word(dir_tab[i].c, dir_tab[i].bv, dir_tab[i].eos);
            if (dir_tab[i].typed) begin
                got = (tok_run.size() == 1) ? tok_run[0] : '0;
                if (tok_run.size() != 1 || got != dir_tab[i].tok) begin
                    $display("%0t: row %0d model exp %h got %h", $realtime, i,
                             dir_tab[i].tok, got);
                    n_fail++;
                end
            end
        end

        // directed rows count toward the item total
        while (n_sent < RAND_ITEMS) begin
            random_fragment();
            case ($urandom_range(0, 29))
                0: send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
                1: send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                2: send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                default: ;
            endcase
        end
        send_word(8'h00, 1'b0, 1'b1);
        in_bus.valid <= 1'b0;

        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (n_fail == 0 && tokens_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
design/lts_pkg.sv
design/lts_if.sv
design/lts_front.sv
design/lts_queue.sv
design/lts_back.sv
design/lua_token_scanner_top.sv
dv/tb_lua_token_scanner_top.sv
